// File: rtl/icf_pkg.sv
package icf_pkg;

	localparam int MAX_WIDTH_DEF = 4096;
	localparam int OUT_DEPTH     = 8;

	localparam int CFG_AW = 4;

	localparam logic [1:0] REG_KERNEL = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;
	localparam logic [1:0] REG_COLOUR = 2'd3;

	localparam logic [2:0] KSEL_SMOOTH  = 3'd0;
	localparam logic [2:0] KSEL_BLUR    = 3'd1;
	localparam logic [2:0] KSEL_SHARPEN = 3'd2;
	localparam logic [2:0] KSEL_MEAN    = 3'd3;
	localparam logic [2:0] KSEL_EMBOSS  = 3'd4;

	localparam logic [2:0]  KERNEL_RST = KSEL_SMOOTH;
	localparam logic [12:0] WIDTH_RST  = 13'd640;
	localparam logic [15:0] HEIGHT_RST = 16'd480;
	localparam logic        COLOUR_RST = 1'b1;

	// reciprocals scaled by 2^RECIP_SH, exact for numerators below 2^RECIP_SH
	localparam int          RECIP_SH = 15;
	localparam logic [13:0] RECIP9   = 14'd3641;
	localparam logic [13:0] RECIP3   = 14'd10923;

	localparam logic CMD_PIXEL = 1'b0;

	typedef struct packed {
		logic       cmd;
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       frame_last;
	} out_beat_t;

	typedef struct packed {
		logic emit;
		logic pixel;
		logic drain;
		logic inner;
		logic last;
	} pipe_ctrl_t;

endpackage

// File: rtl/icf_line_store.sv
module icf_line_store #(
	parameter int DEPTH = icf_pkg::MAX_WIDTH_DEF,
	parameter int AW    = $clog2(icf_pkg::MAX_WIDTH_DEF)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [23:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [23:0]   rdata
);

	logic [23:0] mem [DEPTH];

	// read returns the contents from before a write at the same edge
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/icf_lane.sv
module icf_lane (
	input  logic            clk,
	input  logic [2:0]      kernel,
	input  logic [8:0][7:0] win,
	output logic [7:0]      res_s4
);

	logic signed [12:0] num;
	logic signed [12:0] num_s3;
	logic [2:0]         kernel_s3;
	logic [12:0]        c13, e13, k13;
	logic [11:0]        u;
	logic [13:0]        mul_k;
	logic [25:0]        prod;
	logic [11:0]        quo;

	always_comb begin
		c13 = 13'(win[4]);
		e13 = 13'(win[1]) + 13'(win[3]) + 13'(win[5]) + 13'(win[7]);
		k13 = 13'(win[0]) + 13'(win[2]) + 13'(win[6]) + 13'(win[8]);
		case (kernel)
			icf_pkg::KSEL_SMOOTH:  num = c13 + e13 + k13;
			icf_pkg::KSEL_BLUR:    num = k13 + (e13 << 1) + (c13 << 2);
			icf_pkg::KSEL_SHARPEN: num = (c13 << 3) + (c13 << 1) + c13 - (e13 << 1);
			icf_pkg::KSEL_MEAN:    num = (c13 << 3) + c13 - e13 - k13;
			icf_pkg::KSEL_EMBOSS:  num = 13'(win[1]) - 13'(win[7]);
			default:               num = c13;
		endcase
	end

	always_ff @(posedge clk) begin
		num_s3    <= num;
		kernel_s3 <= kernel;
	end

	// negative clamps to zero, then divide by constant and saturate
	always_comb begin
		u     = num_s3[12] ? 12'd0 : num_s3[11:0];
		mul_k = (kernel_s3 == icf_pkg::KSEL_SMOOTH) ? icf_pkg::RECIP9 : icf_pkg::RECIP3;
		prod  = 26'(u) * 26'(mul_k);
		case (kernel_s3)
			icf_pkg::KSEL_SMOOTH,
			icf_pkg::KSEL_SHARPEN: quo = 12'(prod[25:icf_pkg::RECIP_SH]);
			icf_pkg::KSEL_BLUR:    quo = u >> 4;
			default:               quo = u;
		endcase
	end

	always_ff @(posedge clk) begin
		res_s4 <= (quo > 12'd255) ? 8'd255 : quo[7:0];
	end

endmodule

// File: rtl/icf_merge.sv
module icf_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  icf_pkg::pipe_ctrl_t  ctrl_s4,
	input  logic [23:0]          cen_s4,
	input  logic [2:0][7:0]      lane_res,
	input  logic                 colour,
	output logic                 res_valid,
	input  logic                 res_ready,
	output icf_pkg::out_beat_t   res
);

	localparam int QAW = $clog2(icf_pkg::OUT_DEPTH);

	icf_pkg::out_beat_t q_mem [icf_pkg::OUT_DEPTH];
	icf_pkg::out_beat_t beat;
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0]   cnt_q;
	logic [2:0][7:0] val;
	logic push, pop;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			val[ch] = ctrl_s4.inner ? lane_res[ch] : cen_s4[8*ch +: 8];
		end
		if (!colour) begin
			val[1] = '0;
			val[2] = '0;
		end
		beat.out_red    = val[0];
		beat.out_green  = val[1];
		beat.out_blue   = val[2];
		beat.frame_last = ctrl_s4.last;
	end

	assign push      = ctrl_s4.emit;
	assign res_valid = (cnt_q != '0);
	assign pop       = res_valid && res_ready;
	assign res       = q_mem[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wp_q] <= beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(push) - (QAW+1)'(pop);
		end
	end

endmodule

// File: rtl/image_3x3_convolution_filter.sv
// image_3x3_convolution_filter
// Streams pixels in raster order through two line stores and a 3x3 window,
// filtering each colour channel with one of five fixed kernels; border pixels
// pass through unchanged.
// Input channel pix/pix_valid/pix_ready: one beat per pixel (cmd pixel) or
// flush (cmd flush). Output channel res/res_valid/res_ready: one beat per
// result, frame_last marking the final pixel of the frame.
// A result belongs to the pixel one row and one column behind the newest
// input; once the frame is in, each further beat (flush or pixel) drains one
// result. Flushes before that yield nothing.
// After its beat is accepted, a result passes ctrl_s1 to ctrl_s4 into the output
// queue and can leave at the next edge. Throughput: one beat per cycle while
// pix_ready is high, since each line store takes one write and one read a cycle.
// The output queue holds eight beats; pix_ready drops only when eight results
// are outstanding, so a stalled receiver holds back the input after that.
// Reset clears counters, window and queue, and loads the register defaults
// (smooth kernel, 640 x 480, RGB). Line stores are not cleared.
// Registers (APB, 4-byte stride): kernel_select, frame_width, frame_height,
// color_mode; write only while the block is idle.
module image_3x3_convolution_filter #(
	parameter int MAX_WIDTH = icf_pkg::MAX_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pix_valid,
	output logic                       pix_ready,
	input  icf_pkg::in_beat_t          pix,
	output logic                       res_valid,
	input  logic                       res_ready,
	output icf_pkg::out_beat_t         res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [icf_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int LW = AW + 1;
	localparam int CW = $clog2(icf_pkg::OUT_DEPTH + 1);

	// configuration registers
	logic [2:0]  kernel_q;
	logic [12:0] fw_q;
	logic [15:0] fh_q;
	logic        colour_q;
	logic        cfg_wr;

	// position state
	logic [AW-1:0] col_q, ocol_q;
	logic [16:0]   row_q, orow_q;
	logic [CW-1:0] cred_q;

	// step decode
	logic [31:0]   fw32, wl32;
	logic [LW-1:0] w_lim;
	logic [15:0]   h_lim;
	logic          wrap, drain, pixel, emit, inner, last;
	logic          orow_end, ocol_end, acc, pop;
	logic [AW-1:0] col0, col_n, ocol_n;
	logic [16:0]   row0, row_n, orow_n;
	logic [LW-1:0] c1, ocol_p1;
	logic [AW-1:0] raddr;
	logic [23:0]   pix24;

	// pipeline
	icf_pkg::pipe_ctrl_t ctrl, ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4;
	logic          sel_s1;
	logic [AW-1:0] c_s1;
	logic [23:0]   pix_s1, dcen_s2, cen_s3, cen_s4;
	logic [23:0]   rd_above, rd_two, above2;
	logic          fwd_q;
	logic [23:0]   fwd_d_q;
	logic [8:0][23:0] win_q;
	logic [2:0][8:0][7:0] lane_win;
	logic [2:0][7:0] lane_res;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q <= icf_pkg::KERNEL_RST;
			fw_q     <= icf_pkg::WIDTH_RST;
			fh_q     <= icf_pkg::HEIGHT_RST;
			colour_q <= icf_pkg::COLOUR_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				icf_pkg::REG_KERNEL: kernel_q <= pwdata[2:0];
				icf_pkg::REG_WIDTH:  fw_q     <= pwdata[12:0];
				icf_pkg::REG_HEIGHT: fh_q     <= pwdata[15:0];
				icf_pkg::REG_COLOUR: colour_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			icf_pkg::REG_KERNEL: prdata = 32'(kernel_q);
			icf_pkg::REG_WIDTH:  prdata = 32'(fw_q);
			icf_pkg::REG_HEIGHT: prdata = 32'(fh_q);
			icf_pkg::REG_COLOUR: prdata = 32'(colour_q);
			default:             prdata = '0;
		endcase
	end

	// ---------------- step decode ----------------
	// Clamp width to 1..MAX_WIDTH and height to at least 1.
	always_comb begin
		fw32  = 32'(fw_q);
		if (fw32 == 32'd0)               wl32 = 32'd1;
		else if (fw32 > 32'(MAX_WIDTH))  wl32 = 32'(MAX_WIDTH);
		else                             wl32 = fw32;
		w_lim = wl32[LW-1:0];
		h_lim = (fh_q == 16'd0) ? 16'd1 : fh_q;
	end

	always_comb begin
		// wrap a column count left over from a wider frame
		wrap  = {1'b0, col_q} >= w_lim;
		col0  = wrap ? '0 : col_q;
		row0  = wrap ? row_q + 17'd1 : row_q;
		drain = row0 >= {1'b0, h_lim};
		pixel = !drain && (pix.cmd == icf_pkg::CMD_PIXEL);
		emit  = drain || (pixel && (row0 >= 17'd2 || (row0 == 17'd1 && col0 != '0)));

		orow_end = (orow_q + 17'd1) >= {1'b0, h_lim};
		ocol_p1  = {1'b0, ocol_q} + LW'(1);
		ocol_end = ocol_p1 >= w_lim;
		inner    = pixel && col0 != '0 && orow_q != '0 && !orow_end
		           && ocol_q != '0 && !ocol_end;
		last     = orow_end && ocol_end;

		c1    = {1'b0, col0} + LW'(1);
		col_n = col0;
		row_n = row0;
		if (pixel) begin
			if (c1 >= w_lim) begin
				col_n = '0;
				row_n = row0 + 17'd1;
			end else begin
				col_n = c1[AW-1:0];
			end
		end

		orow_n = orow_q;
		ocol_n = ocol_q;
		if (emit) begin
			if (last) begin
				// frame done: restart every position counter
				col_n  = '0;
				row_n  = '0;
				orow_n = '0;
				ocol_n = '0;
			end else if (ocol_end) begin
				ocol_n = '0;
				orow_n = orow_q + 17'd1;
			end else begin
				ocol_n = ocol_p1[AW-1:0];
			end
		end

		ctrl.emit  = emit;
		ctrl.pixel = pixel;
		ctrl.drain = drain;
		ctrl.inner = inner;
		ctrl.last  = last;

		// a drain beat reads the store at the output column
		raddr = pixel ? col0 : ocol_q;
		pix24 = {pix.in_blue, pix.in_green, pix.in_red};
	end

	// credit: results accepted but not yet taken, never above the queue depth
	assign pix_ready = cred_q < CW'(icf_pkg::OUT_DEPTH);
	assign acc       = pix_valid && pix_ready;
	assign pop       = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			cred_q <= '0;
		end else begin
			if (acc) begin
				col_q  <= col_n;
				row_q  <= row_n;
				ocol_q <= ocol_n;
				orow_q <= orow_n;
			end
			cred_q <= cred_q + CW'(acc && emit) - CW'(pop);
		end
	end

	// ---------------- line stores ----------------
	icf_line_store #(.DEPTH(MAX_WIDTH), .AW(AW)) u_row_above (
		.clk   (clk),
		.we    (acc && pixel),
		.waddr (col0),
		.wdata (pix24),
		.raddr (raddr),
		.rdata (rd_above)
	);

	// the older row is written in the cycle after the newer one, with what the newer row held
	icf_line_store #(.DEPTH(MAX_WIDTH), .AW(AW)) u_two_above (
		.clk   (clk),
		.we    (ctrl_s1.pixel),
		.waddr (c_s1),
		.wdata (rd_above),
		.raddr (raddr),
		.rdata (rd_two)
	);

	// forward that late write when the same entry is read at its edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else begin
			fwd_q <= ctrl_s1.pixel && (c_s1 == raddr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_d_q <= rd_above;
	end

	assign above2 = fwd_q ? fwd_d_q : rd_two;

	// ---------------- pipeline control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
			ctrl_s4 <= '0;
		end else begin
			ctrl_s1 <= acc ? ctrl : '0;
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
			ctrl_s4 <= ctrl_s3;
		end
	end

	always_ff @(posedge clk) begin
		sel_s1  <= orow_end;
		c_s1    <= col0;
		pix_s1  <= pix24;
		dcen_s2 <= sel_s1 ? rd_above : above2;
		cen_s3  <= ctrl_s2.drain ? dcen_s2 : win_q[4];
		cen_s4  <= cen_s3;
	end

	// window: shift left, new column from the two stores and the pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (ctrl_s1.pixel) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= above2;
			win_q[3] <= win_q[4];
			win_q[4] <= win_q[5];
			win_q[5] <= rd_above;
			win_q[6] <= win_q[7];
			win_q[7] <= win_q[8];
			win_q[8] <= pix_s1;
		end
	end

	// ---------------- channel lanes ----------------
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			for (int i = 0; i < 9; i++) begin
				lane_win[ch][i] = win_q[i][8*ch +: 8];
			end
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_lane
		icf_lane u_lane (
			.clk    (clk),
			.kernel (kernel_q),
			.win    (lane_win[g]),
			.res_s4 (lane_res[g])
		);
	end

	// ---------------- merge and output queue ----------------
	icf_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl_s4   (ctrl_s4),
		.cen_s4    (cen_s4),
		.lane_res  (lane_res),
		.colour    (colour_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

// File: rtl/icf_checker.sv
module icf_assertions (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       pix_valid,
	input logic                       pix_ready,
	input logic                       res_valid,
	input logic                       res_ready,
	input icf_pkg::out_beat_t         res,
	input logic                       pready
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result beat changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> pix_ready)
		else $error("input held back with empty output queue");

	a_empty_after_reset: assert property (@(posedge clk)
		!arst_n |=> !res_valid)
		else $error("result beat present straight after reset");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind image_3x3_convolution_filter icf_assertions u_icf_assertions (.*);

// File: tb/icf_checker.sv
module icf_checker
	import icf_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pix_valid,
	input  logic                pix_ready,
	input  in_beat_t            pix,
	input  logic                res_valid,
	input  logic                res_ready,
	input  out_beat_t           res,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CFG_AW-1:0]   paddr,
	input  logic [31:0]         pwdata,
	input  logic                pready,
	output int                  errors,
	output int                  pending,
	output int                  results_seen
);

	logic [23:0] line_up [MAX_WIDTH];
	logic [23:0] line_up2 [MAX_WIDTH];
	logic [23:0] win [9];
	int col_in, row_in, col_out, row_out;
	logic [2:0]  kern;
	logic [12:0] fw;
	logic [15:0] fh;
	logic        rgb;
	out_beat_t   due_beats[$];

	function automatic logic [7:0] clip(int num, int den);
		int q;
		if (num < 0)
			return 8'd0;
		q = num / den;
		return (q > 255) ? 8'd255 : q[7:0];
	endfunction

	function automatic logic [7:0] convolve(int ch);
		int v[9];
		int c, edges, corners;
		for (int i = 0; i < 9; i++)
			v[i] = win[i][8*ch +: 8];
		c = v[4];
		edges = v[1] + v[3] + v[5] + v[7];
		corners = v[0] + v[2] + v[6] + v[8];
		case (kern)
			KSEL_SMOOTH:  return clip(c + edges + corners, 9);
			KSEL_BLUR:    return clip(corners + 2 * edges + 4 * c, 16);
			KSEL_SHARPEN: return clip(11 * c - 2 * edges, 3);
			KSEL_MEAN:    return clip(9 * c - edges - corners, 1);
			KSEL_EMBOSS:  return clip(v[1] - v[7], 1);
			default:      return c[7:0];
		endcase
	endfunction

	task automatic queue_result(logic [23:0] centre, bit inner, int w, int h);
		logic [7:0] val[3];
		out_beat_t e;
		for (int ch = 0; ch < 3; ch++) begin
			val[ch] = inner ? convolve(ch) : centre[8*ch +: 8];
			if (!rgb && ch != 0)
				val[ch] = 8'd0;
		end
		e.out_red = val[0];
		e.out_green = val[1];
		e.out_blue = val[2];
		e.frame_last = (row_out + 1 >= h) && (col_out + 1 >= w);
		if (e.frame_last) begin
			row_in = 0;
			col_in = 0;
			row_out = 0;
			col_out = 0;
		end else begin
			col_out++;
			if (col_out >= w) begin
				col_out = 0;
				row_out++;
			end
		end
		due_beats.push_back(e);
	endtask

	task automatic filter_step(in_beat_t b);
		int w, h, r, c;
		logic [23:0] px, up, up2, old_mid;
		bit inner;
		w = fw;
		h = fh;
		if (w < 1) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		if (h < 1) h = 1;
		if (col_in >= w) begin
			col_in = 0;
			row_in++;
		end
		// frame fully in: every beat drains one result
		if (row_in >= h) begin
			queue_result((row_out + 1 >= h) ? line_up[col_out] : line_up2[col_out], 1'b0, w, h);
			return;
		end
		if (b.cmd != CMD_PIXEL)
			return;
		r = row_in;
		c = col_in;
		px = {b.in_blue, b.in_green, b.in_red};
		up2 = line_up2[c];
		up = line_up[c];
		line_up2[c] = up;
		line_up[c] = px;
		old_mid = win[5];
		for (int i = 0; i < 3; i++) begin
			win[i*3] = win[i*3+1];
			win[i*3+1] = win[i*3+2];
		end
		win[2] = up2;
		win[5] = up;
		win[8] = px;
		col_in = c + 1;
		if (col_in >= w) begin
			col_in = 0;
			row_in = r + 1;
		end
		if (!(r >= 2 || (r == 1 && c >= 1)))
			return;
		inner = c >= 1 && row_out >= 1 && row_out + 1 < h && col_out >= 1 && col_out + 1 < w;
		queue_result((c == 0) ? old_mid : win[4], inner, w, h);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++)
				win[i] = '0;
			col_in = 0;
			row_in = 0;
			col_out = 0;
			row_out = 0;
			kern = KERNEL_RST;
			fw = WIDTH_RST;
			fh = HEIGHT_RST;
			rgb = COLOUR_RST;
			errors = 0;
			results_seen = 0;
			due_beats.delete();
			pending = 0;
		end else begin
			if (res_valid && res_ready) begin
				results_seen++;
				if (due_beats.size() == 0) begin
					errors++;
					$display("%0t: unexpected result beat %h", $time, res);
				end else begin
					out_beat_t e;
					e = due_beats.pop_front();
					if (e.out_red !== res.out_red || e.out_green !== res.out_green ||
					    e.out_blue !== res.out_blue || e.frame_last !== res.frame_last) begin
						errors++;
						$display("%0t: mismatch expected r=%0d g=%0d b=%0d last=%0b,",
							$time, e.out_red, e.out_green, e.out_blue, e.frame_last);
						$display("    actual r=%0d g=%0d b=%0d last=%0b",
							res.out_red, res.out_green, res.out_blue, res.frame_last);
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_KERNEL: kern = pwdata[2:0];
					REG_WIDTH:  fw = pwdata[12:0];
					REG_HEIGHT: fh = pwdata[15:0];
					REG_COLOUR: rgb = pwdata[0];
					default: ;
				endcase
			end
			if (pix_valid && pix_ready)
				filter_step(pix);
			pending = due_beats.size();
		end
	end

endmodule

// File: tb/testbench.sv
module testbench;
	import icf_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        pix_valid = 1'b0;
	logic        pix_ready;
	in_beat_t    pix = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	out_beat_t   res;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int  errors, pending, results_seen;
	int  beats_sent = 0;
	int  frames_run = 0;
	bit  calm = 0;       // no idling on either side
	bit  hold_req = 0;   // ask the receiver for one long hold-off

	always #2 clk = ~clk;

	image_3x3_convolution_filter dut (.*);

	icf_checker chk (.*);

	// Receiver: random bursts of stall and flow, plus one long hold on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_ready = 1'b0;
				repeat (300) @(negedge clk);
				hold_req = 0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				res_ready = 1'b0;
				n = $urandom_range(1, 16);
				repeat (n - 1) @(negedge clk);
			end else begin
				res_ready = 1'b1;
				n = $urandom_range(1, 16);
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	// Hard limit on the run
	initial begin
		#4000000;
		$display("TEST FAILED");
		$finish;
	end

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Offer one beat and hold it until accepted; valid stays high afterwards
	task automatic send_beat(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int n;
		if (!calm && $urandom_range(0, 5) == 0) begin
			pix_valid = 1'b0;
			n = $urandom_range(1, 16);
			repeat (n) @(negedge clk);
		end
		pix_valid = 1'b1;
		pix = '{cmd: cmd, in_red: r, in_green: g, in_blue: b};
		do @(posedge clk); while (!pix_ready);
		@(negedge clk);
		beats_sent++;
	endtask

	// Settle: all results in, then allow the pipeline to empty
	task automatic settle();
		pix_valid = 1'b0;
		wait (pending == 0);
		repeat (20) @(negedge clk);
	endtask

	function automatic logic [7:0] sample_value(int style);
		case (style)
			1: return 8'd0;
			2: return 8'd255;
			3: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Configure, stream one frame, then drain it with flushes (some pixels among them)
	task automatic run_frame(int w, int h, int k, int mode, int style, bit noisy);
		int ew, eh, tail;
		settle();
		reg_write(REG_KERNEL, k);
		reg_write(REG_WIDTH, w);
		reg_write(REG_HEIGHT, h);
		reg_write(REG_COLOUR, mode);
		ew = (w < 1) ? 1 : ((w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w);
		eh = (h < 1) ? 1 : h;
		for (int i = 0; i < ew * eh; i++) begin
			// early flush: frame not in yet, nothing comes out
			if (noisy && $urandom_range(0, 15) == 0)
				send_beat(~CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
			send_beat(CMD_PIXEL, sample_value(style), sample_value(style), sample_value(style));
		end
		tail = (ew * eh < ew + 1) ? ew * eh : ew + 1;
		for (int i = 0; i < tail; i++) begin
			// a pixel during the drain counts as a flush
			if (noisy && $urandom_range(0, 3) == 0)
				send_beat(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
			else
				send_beat(~CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
		end
		// stray flushes at the start of the next frame yield nothing
		if (noisy)
			repeat ($urandom_range(0, 2))
				send_beat(~CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
		frames_run++;
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Directed: every kernel plus unused codes, extreme values, grey mode
		for (int k = 0; k < 8; k++)
			run_frame(3, 3, k, 1, 0, 0);
		run_frame(4, 4, KSEL_SHARPEN, 1, 2, 0);
		run_frame(4, 4, KSEL_MEAN, 1, 3, 0);
		run_frame(4, 3, KSEL_EMBOSS, 0, 3, 1);
		run_frame(1, 1, KSEL_BLUR, 1, 0, 1);
		run_frame(0, 0, KSEL_SMOOTH, 0, 1, 1);
		run_frame(2, 5, KSEL_SMOOTH, 1, 2, 1);

		// Random frames, mostly small
		while (beats_sent < 1100) begin
			run_frame($urandom_range(1, 10), $urandom_range(1, 8), $urandom_range(0, 7),
				$urandom_range(0, 1), $urandom_range(0, 4), 1);
		end

		// Fill the output queue: receiver holds off while the sender keeps going
		settle();
		hold_req = 1;
		run_frame(12, 12, KSEL_BLUR, 1, 0, 0);

		// Sender pauses mid-frame until every result is out
		settle();
		reg_write(REG_KERNEL, KSEL_SMOOTH);
		reg_write(REG_WIDTH, 5);
		reg_write(REG_HEIGHT, 5);
		reg_write(REG_COLOUR, 1);
		for (int i = 0; i < 25; i++) begin
			send_beat(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
			if (i == 15) begin
				pix_valid = 1'b0;
				wait (pending == 0);
				@(negedge clk);
			end
		end
		repeat (6) send_beat(~CMD_PIXEL, 8'd0, 8'd0, 8'd0);

		// Last part without idling
		calm = 1;
		run_frame(1, 12, KSEL_EMBOSS, 1, 0, 0);
		run_frame(7, 6, KSEL_SHARPEN, 1, 0, 1);

		settle();
		repeat (20) @(negedge clk);
		$display("Covered %0d frames over all kernels, both colour modes and clamped sizes;", frames_run);
		$display("%0d input beats offered, %0d result beats checked.", beats_sent, results_seen);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
